// ===== sv/ptwa_pkg.sv =====
// Shared types and codes for the peer table with aging.
// Depends on nothing; imported by the peer table top level.
`default_nettype none

package ptwa_pkg;

    // Action codes carried in the action field of an input transaction.
    typedef enum logic [1:0] {
        ACT_ANNOUNCE = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_CLEAN    = 2'd2,
        ACT_NOP      = 2'd3
    } action_t;

    // Status codes of a result transaction.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Reset value of the age limit register.
    localparam logic [15:0] AGE_LIMIT_RESET = 16'd10;

    // One word of the slot memory: peer address and last-seen time.
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] seen;
    } slot_entry_t;

endpackage

`default_nettype wire

// ===== sv/peer_table_with_aging.sv =====
// Peer table with aging: top level, slot memory and scan sequencer.
// Depends on ptwa_pkg for action codes, status codes and the slot word type.
`default_nettype none

// Keeps up to TABLE_SLOTS IPv4 peer addresses with their last-seen tick.
// Each input transaction yields exactly one result transaction. A tick or an
// unused action goes straight to the finish state, which loads its result
// once the output register is free. An announce or a clean walks the slot
// memory through its single read port, one slot per cycle with the compare
// in the cycle after the read; an announce that hits a slot stops there.
// The next item is taken the cycle after a result is loaded. The block
// accepts one item at a time and takes the next one while the previous
// result still waits on a stalled output. Valid bits live in flip-flops
// and are cleared at reset, so no clearing pass is needed.
// The age limit register may be written only while the block is idle.
module peer_table_with_aging #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port for the age limit.
    input  wire logic        age_limit_we,
    input  wire logic [15:0] age_limit_data,
    // Input channel.
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] peer_address,
    // Result channel.
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             status,
    output logic             was_known,
    output logic [4:0]       entry_count,
    output logic [4:0]       removed_count
);

    import ptwa_pkg::*;

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [15:0]            age_limit_reg;
    logic [31:0]            now_ticks_reg;
    logic [TABLE_SLOTS-1:0] slot_valid_reg;
    logic [CW-1:0]          live_count_reg;

    // Item held for the scan.
    action_t                act_reg;
    logic [31:0]            addr_reg;

    // Scan pipeline: read issue, and compare in the cycle after the read.
    logic                   issue_on_reg;
    logic [IW-1:0]          issue_idx_reg;
    logic                   check_on_reg;
    logic [IW-1:0]          check_idx_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;
    logic [CW-1:0]          removed_reg;

    // Result waiting for the output register.
    logic                   res_status_reg;
    logic                   res_known_reg;
    logic [CW-1:0]          res_removed_reg;

    // Output register.
    logic                   result_valid_reg;
    logic                   status_reg;
    logic                   was_known_reg;
    logic [CW-1:0]          entry_count_reg;
    logic [CW-1:0]          removed_count_reg;

    // Slot memory with one write port and one registered read port.
    slot_entry_t            slot_mem [TABLE_SLOTS];
    slot_entry_t            rd_data_reg;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    slot_entry_t            mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[issue_idx_reg];
    end

    // Handshake and compare logic.
    logic        item_take;
    logic        out_free;
    logic        check_valid;
    logic        addr_hit;
    logic        scan_hit;
    logic        free_here;
    logic [31:0] age;
    logic        age_expired;
    logic        last_check;
    logic        insert_ok;
    logic [IW-1:0] insert_idx;

    assign item_take   = item_valid && (state_reg == ST_IDLE);
    assign out_free    = !result_valid_reg || !result_stall;
    assign check_valid = check_on_reg && slot_valid_reg[check_idx_reg];
    assign addr_hit    = check_valid && (rd_data_reg.address == addr_reg);
    assign scan_hit    = (act_reg == ACT_ANNOUNCE) && addr_hit;
    assign free_here   = check_on_reg && !slot_valid_reg[check_idx_reg];
    assign age         = now_ticks_reg - rd_data_reg.seen;
    assign age_expired = check_valid && (age > {16'd0, age_limit_reg});
    assign last_check  = check_on_reg && (check_idx_reg == LAST_IDX);
    assign insert_ok   = free_found_reg || free_here;
    assign insert_idx  = free_found_reg ? free_idx_reg : check_idx_reg;

    // Memory write: refresh on a hit, insert at the end of a missed scan.
    always_comb
    begin
        mem_we            = 1'b0;
        mem_waddr         = check_idx_reg;
        mem_wdata.address = addr_reg;
        mem_wdata.seen    = now_ticks_reg;
        if (state_reg == ST_SCAN && act_reg == ACT_ANNOUNCE)
        begin
            if (addr_hit)
            begin
                mem_we = 1'b1;
            end
            else if (last_check && insert_ok)
            begin
                mem_we    = 1'b1;
                mem_waddr = insert_idx;
            end
        end
    end

    // Sequencer state, table control state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            age_limit_reg     <= AGE_LIMIT_RESET;
            now_ticks_reg     <= '0;
            slot_valid_reg    <= '0;
            live_count_reg    <= '0;
            issue_on_reg      <= 1'b0;
            issue_idx_reg     <= '0;
            check_on_reg      <= 1'b0;
            check_idx_reg     <= '0;
            free_found_reg    <= 1'b0;
            free_idx_reg      <= '0;
            removed_reg       <= '0;
            result_valid_reg  <= 1'b0;
            act_reg           <= ACT_NOP;
            addr_reg          <= '0;
            res_status_reg    <= STATUS_DONE;
            res_known_reg     <= 1'b0;
            res_removed_reg   <= '0;
            status_reg        <= STATUS_DONE;
            was_known_reg     <= 1'b0;
            entry_count_reg   <= '0;
            removed_count_reg <= '0;
        end
        else
        begin
            if (age_limit_we)
            begin
                age_limit_reg <= age_limit_data;
            end

            // A taken result leaves unless a new one replaces it this cycle.
            if (result_valid_reg && !result_stall && state_reg != ST_FINISH)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_take)
                    begin
                        act_reg         <= action_t'(action);
                        addr_reg        <= peer_address;
                        issue_on_reg    <= 1'b1;
                        issue_idx_reg   <= '0;
                        check_on_reg    <= 1'b0;
                        free_found_reg  <= 1'b0;
                        removed_reg     <= '0;
                        res_status_reg  <= STATUS_DONE;
                        res_known_reg   <= 1'b0;
                        res_removed_reg <= '0;
                        case (action_t'(action)) inside
                            ACT_ANNOUNCE, ACT_CLEAN:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            ACT_TICK:
                            begin
                                now_ticks_reg <= now_ticks_reg + 32'd1;
                                state_reg     <= ST_FINISH;
                            end
                            default:
                            begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    // Advance the read side of the walk; a hit ends it at once.
                    check_on_reg  <= issue_on_reg && !scan_hit;
                    check_idx_reg <= issue_idx_reg;
                    if (issue_on_reg)
                    begin
                        if (issue_idx_reg == LAST_IDX || scan_hit)
                        begin
                            issue_on_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_idx_reg <= issue_idx_reg + IW'(1);
                        end
                    end

                    if (act_reg == ACT_ANNOUNCE)
                    begin
                        // Remember the lowest free slot seen so far.
                        if (free_here && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= check_idx_reg;
                        end
                        if (addr_hit)
                        begin
                            res_known_reg <= 1'b1;
                            state_reg     <= ST_FINISH;
                        end
                        else if (last_check)
                        begin
                            if (insert_ok)
                            begin
                                slot_valid_reg[insert_idx] <= 1'b1;
                                live_count_reg <= live_count_reg + CW'(1);
                            end
                            else
                            begin
                                res_status_reg <= STATUS_FULL;
                            end
                            state_reg <= ST_FINISH;
                        end
                    end
                    else
                    begin
                        // Clean: drop each expired slot as it is checked.
                        if (age_expired)
                        begin
                            slot_valid_reg[check_idx_reg] <= 1'b0;
                            removed_reg    <= removed_reg + CW'(1);
                            live_count_reg <= live_count_reg - CW'(1);
                        end
                        if (last_check)
                        begin
                            res_removed_reg <= removed_reg + CW'(age_expired);
                            state_reg       <= ST_FINISH;
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        result_valid_reg  <= 1'b1;
                        status_reg        <= res_status_reg;
                        was_known_reg     <= res_known_reg;
                        entry_count_reg   <= live_count_reg;
                        removed_count_reg <= res_removed_reg;
                        state_reg         <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output fields masked to five bits for any table size.
    logic [CW+4:0] entry_ext;
    logic [CW+4:0] removed_ext;

    assign entry_ext     = {5'd0, entry_count_reg};
    assign removed_ext   = {5'd0, removed_count_reg};
    assign item_stall    = (state_reg != ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign was_known     = was_known_reg;
    assign entry_count   = entry_ext[4:0];
    assign removed_count = removed_ext[4:0];

`ifndef ASSERT_OFF
    // The live count always matches the number of valid bits.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg == CW'($countones(slot_valid_reg)))
        else $error("live count differs from valid bits");

    // The live count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= CW'(TABLE_SLOTS))
        else $error("live count above table size");

    // The compare stage trails the read stage by exactly one slot.
    a_scan_lag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && check_on_reg && issue_on_reg)
            |-> (issue_idx_reg == check_idx_reg + IW'(1)))
        else $error("scan pipeline out of step");

    // A new result is only loaded out of the finish state.
    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish state");

    // A full report never claims a hit or a removal.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg == STATUS_FULL)
            |-> (!was_known_reg && removed_count_reg == '0))
        else $error("inconsistent table full result");
`endif

endmodule

`default_nettype wire
